// ===== sv/rsat_pkg.sv =====
package rsat_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 8;
   localparam int SLOTS       = 2 * TABLE_DEPTH;
   localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = $clog2(SLOTS);
   localparam int COUNT_W     = 4;
   localparam int EXT_W       = FILL_W + COUNT_W;

   // Command codes and address classes.
   localparam logic       CMD_UPDATE     = 1'b0;
   localparam logic       CMD_READ       = 1'b1;
   localparam logic [7:0] LOOPBACK_OCTET = 8'd127;
   localparam logic [31:0] ADDR_ZERO     = 32'd0;
   localparam logic [31:0] ADDR_ONE      = 32'd1;
   localparam logic [15:0] PORT_NONE     = 16'd0;

   typedef struct packed {
      logic        command;
      logic        list_select;
      logic [31:0] ip_address;
      logic [15:0] port_number;
      logic [31:0] seen_time;
      logic [7:0]  source_tag;
      logic [2:0]  read_index;
   } req_type;

   typedef struct packed {
      logic               is_new;
      logic [COUNT_W-1:0] entry_count;
      logic               read_valid;
      logic [31:0]        out_address;
      logic [15:0]        out_port;
      logic [31:0]        out_seen_time;
      logic [7:0]         out_source_tag;
   } rsp_type;

   typedef struct packed {
      logic [31:0] address;
      logic [15:0] port;
      logic [31:0] seen_time;
      logic [7:0]  tag;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   // Memory slot of a position within the selected table.
   function automatic logic [ADDR_W-1:0] slot_addr(input logic sel,
                                                   input logic [FILL_W-1:0] idx);
      logic [ADDR_W:0] base;
      logic [ADDR_W:0] sum;
      base = sel ? (ADDR_W + 1)'(TABLE_DEPTH) : '0;
      sum  = base + (ADDR_W + 1)'(idx);
      return sum[ADDR_W-1:0];
   endfunction

   // Fill count as reported, masked to the count field.
   function automatic logic [COUNT_W-1:0] count_field(input logic [FILL_W-1:0] fill);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(fill);
      return ext[COUNT_W-1:0];
   endfunction

endpackage

// ===== sv/rsat_entry_ram.sv =====
module rsat_entry_ram (
   input  logic                 clock,
   input  rsat_pkg::ram_req_type ram_req,
   output rsat_pkg::entry_type   rd_data
);
   import rsat_pkg::*;

   entry_type entry_mem [SLOTS];
   entry_type rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         entry_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= entry_mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rsat_ctrl.sv =====
module rsat_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rsat_pkg::req_type     req_data,
   input  logic                  out_free,
   output logic                  res_load,
   output rsat_pkg::rsp_type     res_data,
   output rsat_pkg::ram_req_type ram_req,
   input  rsat_pkg::entry_type   ram_rd_data
);
   import rsat_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SCAN   = 8'b0000_0010,
      ST_DECIDE = 8'b0000_0100,
      ST_SHIFT  = 8'b0000_1000,
      ST_WRITE  = 8'b0001_0000,
      ST_READ   = 8'b0010_0000,
      ST_FETCH  = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           res_ff, res_in;
   logic [FILL_W-1:0] fill_local_ff, fill_local_in;
   logic [FILL_W-1:0] fill_ext_ff, fill_ext_in;
   logic [FILL_W-1:0] rd_idx_ff, rd_idx_in;
   logic              chk_pend_ff, chk_pend_in;
   logic [FILL_W-1:0] chk_idx_ff, chk_idx_in;
   logic              dup_ff, dup_in;
   logic              dup_newer_ff, dup_newer_in;
   logic [FILL_W-1:0] dup_idx_ff, dup_idx_in;
   logic              older_ff, older_in;
   logic [FILL_W-1:0] older_idx_ff, older_idx_in;
   logic [FILL_W-1:0] pos_ff, pos_in;
   logic [FILL_W-1:0] src_ff, src_in;
   logic [FILL_W-1:0] dst_ff, dst_in;
   logic [FILL_W-1:0] left_ff, left_in;
   logic              up_ff, up_in;

   logic [FILL_W-1:0] cur_fill;
   logic              key_match;
   logic              invalid_addr;
   logic              table_full;
   logic              reject;
   logic [FILL_W-1:0] first_older;
   logic [FILL_W-1:0] fill_kept;
   logic [FILL_W-1:0] fill_after;
   logic [FILL_W-1:0] ins_pos;
   logic [FILL_W-1:0] shift_hi;
   logic              shift_up;
   logic [FILL_W-1:0] moves;
   logic [EXT_W-1:0]  idx_ext;
   logic              read_ok;

   // Fill of the table named by the item in hand.
   assign cur_fill  = req_ff.list_select ? fill_ext_ff : fill_local_ff;
   assign key_match = (ram_rd_data.address == req_ff.ip_address) &&
                      (ram_rd_data.port == req_ff.port_number);

   // Decision terms, valid once the scan has finished.
   assign invalid_addr = (req_ff.ip_address[31:24] == LOOPBACK_OCTET) ||
                         (req_ff.ip_address == ADDR_ZERO) ||
                         (req_ff.ip_address == ADDR_ONE) ||
                         (req_ff.port_number == PORT_NONE);
   assign table_full  = (cur_fill == FILL_W'(TABLE_DEPTH));
   assign reject      = invalid_addr || (table_full && !older_ff) ||
                        (dup_ff && dup_newer_ff);
   assign first_older = older_ff ? older_idx_ff : cur_fill;
   assign fill_kept   = cur_fill - FILL_W'(dup_ff);
   assign fill_after  = (fill_kept < FILL_W'(TABLE_DEPTH)) ? fill_kept + FILL_W'(1)
                                                           : fill_kept;
   // Removing the duplicate above the insertion point pulls that point up by one.
   assign ins_pos     = (dup_ff && (dup_idx_ff < first_older)) ? first_older - FILL_W'(1)
                                                              : first_older;
   assign shift_hi    = dup_ff ? dup_idx_ff
                               : (table_full ? FILL_W'(TABLE_DEPTH - 1) : cur_fill);
   assign shift_up    = dup_ff && (ins_pos > dup_idx_ff);
   assign moves       = shift_up ? ins_pos - dup_idx_ff : shift_hi - ins_pos;

   // Read command range check.
   assign idx_ext = EXT_W'(req_ff.read_index);
   assign read_ok = (idx_ext < EXT_W'(cur_fill)) && (idx_ext < EXT_W'(TABLE_DEPTH));

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      fill_local_in = fill_local_ff;
      fill_ext_in   = fill_ext_ff;
      rd_idx_in     = rd_idx_ff;
      chk_pend_in   = 1'b0;
      chk_idx_in    = chk_idx_ff;
      dup_in        = dup_ff;
      dup_newer_in  = dup_newer_ff;
      dup_idx_in    = dup_idx_ff;
      older_in      = older_ff;
      older_idx_in  = older_idx_ff;
      pos_in        = pos_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      left_in       = left_ff;
      up_in         = up_ff;
      ram_req       = '0;
      res_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               rd_idx_in = '0;
               dup_in    = 1'b0;
               older_in  = 1'b0;
               state_in  = (req_data.command == CMD_READ) ? ST_READ : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Check the entry read in the previous cycle.
            if (chk_pend_ff) begin
               if (!dup_ff && key_match) begin
                  dup_in       = 1'b1;
                  dup_idx_in   = chk_idx_ff;
                  dup_newer_in = ram_rd_data.seen_time > req_ff.seen_time;
               end
               if (!older_ff && (ram_rd_data.seen_time < req_ff.seen_time)) begin
                  older_in     = 1'b1;
                  older_idx_in = chk_idx_ff;
               end
            end
            if (rd_idx_ff < cur_fill) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = slot_addr(req_ff.list_select, rd_idx_ff);
               rd_idx_in       = rd_idx_ff + FILL_W'(1);
               chk_pend_in     = 1'b1;
               chk_idx_in      = rd_idx_ff;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_in             = '0;
            res_in.entry_count = count_field(cur_fill);
            if (reject) begin
               state_in = ST_FINISH;
            end else if (ins_pos >= FILL_W'(TABLE_DEPTH)) begin
               // The offer would land past the end: only the removal stands.
               res_in.is_new      = !dup_ff;
               res_in.entry_count = count_field(fill_kept);
               if (req_ff.list_select) begin
                  fill_ext_in = fill_kept;
               end else begin
                  fill_local_in = fill_kept;
               end
               state_in = ST_FINISH;
            end else begin
               res_in.is_new      = !dup_ff;
               res_in.entry_count = count_field(fill_after);
               if (req_ff.list_select) begin
                  fill_ext_in = fill_after;
               end else begin
                  fill_local_in = fill_after;
               end
               pos_in  = ins_pos;
               up_in   = shift_up;
               left_in = moves;
               if (moves == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  src_in          = shift_up ? dup_idx_ff + FILL_W'(1) : shift_hi - FILL_W'(1);
                  dst_in          = shift_up ? dup_idx_ff : shift_hi;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = slot_addr(req_ff.list_select, src_in);
                  state_in        = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // Write the entry fetched last cycle one place along, fetch the next.
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = slot_addr(req_ff.list_select, dst_ff);
            ram_req.wr_data = ram_rd_data;
            left_in         = left_ff - FILL_W'(1);
            if (left_ff > FILL_W'(1)) begin
               src_in          = up_ff ? src_ff + FILL_W'(1) : src_ff - FILL_W'(1);
               dst_in          = up_ff ? dst_ff + FILL_W'(1) : dst_ff - FILL_W'(1);
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = slot_addr(req_ff.list_select, src_in);
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_req.wr_en             = 1'b1;
            ram_req.wr_addr           = slot_addr(req_ff.list_select, pos_ff);
            ram_req.wr_data.address   = req_ff.ip_address;
            ram_req.wr_data.port      = req_ff.port_number;
            ram_req.wr_data.seen_time = req_ff.seen_time;
            ram_req.wr_data.tag       = req_ff.source_tag;
            state_in                  = ST_FINISH;
         end
         ST_READ: begin
            res_in             = '0;
            res_in.entry_count = count_field(cur_fill);
            res_in.read_valid  = read_ok;
            if (read_ok) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = slot_addr(req_ff.list_select, idx_ext[FILL_W-1:0]);
               state_in        = ST_FETCH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FETCH: begin
            res_in.out_address    = ram_rd_data.address;
            res_in.out_port       = ram_rd_data.port;
            res_in.out_seen_time  = ram_rd_data.seen_time;
            res_in.out_source_tag = ram_rd_data.tag;
            state_in              = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_local_ff <= '0;
         fill_ext_ff   <= '0;
         chk_pend_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_local_ff <= fill_local_in;
         fill_ext_ff   <= fill_ext_in;
         chk_pend_ff   <= chk_pend_in;
      end
   end

   // Working registers of the item in hand.
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      res_ff       <= res_in;
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      dup_ff       <= dup_in;
      dup_newer_ff <= dup_newer_in;
      dup_idx_ff   <= dup_idx_in;
      older_ff     <= older_in;
      older_idx_ff <= older_idx_in;
      pos_ff       <= pos_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      left_ff      <= left_in;
      up_ff        <= up_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_data  = res_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_local_ff <= FILL_W'(TABLE_DEPTH)) && (fill_ext_ff <= FILL_W'(TABLE_DEPTH)))
      else $error("table fill exceeds the table depth");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
      else $error("entry written and read at the same slot in one cycle");

   a_fill_from_decide: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (!$stable(fill_local_ff) || !$stable(fill_ext_ff)))
      |-> ($past(state_ff) == ST_DECIDE))
      else $error("table fill changed outside the decision step");

   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (left_ff != '0))
      else $error("shift step entered with no entries left to move");
`endif

endmodule

// ===== sv/recency_sorted_address_table.sv =====
// Recency-sorted address table: two tables, local and external, of address and
// port entries, each kept newest first by seen time.
// Input channel req_valid / req_stall / req_data carries one item: an update
// offer or a read of one entry. Result channel rsp_valid / rsp_stall / rsp_data
// returns exactly one result item for every input item, in order.
// An update scans the selected table one entry per cycle through the entry
// memory's read port, then moves entries one slot per cycle to close the gap of
// a replaced entry or open a place for the new one, then writes the new entry.
// A rejected update goes from the decision straight to its result. The next
// item is taken only once the result has entered the output register. A read
// fetches the indexed entry; an index past the fill gives a result with
// read_valid low and no fetch.
// Reset empties both tables at once by clearing their fill counts; no memory
// pass is needed and an item can be taken as soon as reset is released.
// A stalled result waits in the output register while the block takes and
// works on the next item; that item's result is held until the register frees.
module recency_sorted_address_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsat_pkg::rsp_type rsp_data
);
   import rsat_pkg::*;

   ram_req_type ram_req;
   entry_type   ram_rd_data;
   rsp_type     res_data;
   logic        res_load;
   logic        out_free;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   rsat_entry_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   rsat_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .out_free    (out_free),
      .res_load    (res_load),
      .res_data    (res_data),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   // Output register: free when empty or being taken this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
